/* rtl/aob_pkg.sv */
// ----------------------------------------------------------------------------
// aob_pkg
// Shared widths and constants for the alpha-over blend pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package aob_pkg;

    // One ARGB8888 channel
    localparam int CH_W        = 8;
    // Colour channels per pixel (blue, green, red)
    localparam int NUM_CH      = 3;
    // 8x8 product and coverage term N (max 65025)
    localparam int PROD_W      = 16;
    // Weighted colour sum plus rounding term, always below 256 * N
    localparam int NUM_W       = 24;
    // Divider layout: quotient bits resolved per stage, and stage count
    localparam int DIV_STEPS   = 2;
    localparam int DIV_STAGES  = CH_W / DIV_STEPS;

    localparam logic [CH_W-1:0]   ALPHA_MAX = 8'hFF;
    // 255 * 255
    localparam logic [PROD_W-1:0] COVER_MAX = 16'd65025;
    // Bias that turns floor(x / 255) into a ceiling
    localparam logic [PROD_W:0]   CEIL_BIAS = 17'd254;

endpackage

`default_nettype wire

/* rtl/aob_divider.sv */
// ----------------------------------------------------------------------------
// aob_divider
// Pipelined restoring divider for one colour channel. The dividend is known
// to be below 256 * divisor, so only the low eight quotient bits exist; the
// high dividend bits seed the remainder and each stage resolves two bits.
// ----------------------------------------------------------------------------
`default_nettype none

module aob_divider
    import aob_pkg::*;
(
    input  wire logic              clk,
    input  wire logic [NUM_W-1:0]  dividend,
    input  wire logic [PROD_W-1:0] divisor,
    output logic      [CH_W-1:0]   quotient
);

    // Partial remainder, divisor and pending dividend bits between stages
    logic [PROD_W-1:0] rem_reg [DIV_STAGES-1];
    logic [PROD_W-1:0] den_reg [DIV_STAGES-1];
    logic [CH_W-1:0]   lo_reg  [DIV_STAGES-1];
    logic [CH_W-1:0]   quo_reg [DIV_STAGES];

    genvar s;
    generate
        for (s = 0; s < DIV_STAGES; s++) begin : g_stage
            logic [PROD_W-1:0] rem_in;
            logic [PROD_W-1:0] den_in;
            logic [CH_W-1:0]   lo_in;
            logic [CH_W-1:0]   quo_in;
            logic [PROD_W-1:0] rem_next;
            logic [CH_W-1:0]   lo_next;
            logic [CH_W-1:0]   quo_next;

            // Stage inputs: ports for the first stage, else previous stage
            if (s == 0) begin : g_first
                assign rem_in = dividend[NUM_W-1:CH_W];
                assign den_in = divisor;
                assign lo_in  = dividend[CH_W-1:0];
                assign quo_in = '0;
            end
            else begin : g_next
                assign rem_in = rem_reg[s-1];
                assign den_in = den_reg[s-1];
                assign lo_in  = lo_reg[s-1];
                assign quo_in = quo_reg[s-1];
            end

            // Two shift / compare / subtract steps
            always_comb
            begin
                logic [PROD_W:0] trial;
                rem_next = rem_in;
                lo_next  = lo_in;
                quo_next = quo_in;
                for (int k = 0; k < DIV_STEPS; k++)
                begin
                    trial   = {rem_next, lo_next[CH_W-1]};
                    lo_next = {lo_next[CH_W-2:0], 1'b0};
                    if (trial >= {1'b0, den_in})
                    begin
                        trial    = trial - {1'b0, den_in};
                        quo_next = {quo_next[CH_W-2:0], 1'b1};
                    end
                    else
                    begin
                        quo_next = {quo_next[CH_W-2:0], 1'b0};
                    end
                    rem_next = trial[PROD_W-1:0];
                end
            end

            // Stage registers; the last stage keeps only the quotient
            always_ff @(posedge clk)
            begin
                quo_reg[s] <= quo_next;
            end

            if (s < DIV_STAGES - 1) begin : g_carry
                always_ff @(posedge clk)
                begin
                    rem_reg[s] <= rem_next;
                    den_reg[s] <= den_in;
                    lo_reg[s]  <= lo_next;
                end
            end
        end
    endgenerate

    assign quotient = quo_reg[DIV_STAGES-1];

endmodule

`default_nettype wire

/* rtl/alpha_over_blend.sv */
// ----------------------------------------------------------------------------
// alpha_over_blend
// Porter-Duff "over" of a foreground on a background ARGB8888 pixel, both
// with straight alpha, in exact integer arithmetic with ceiling rounding.
//
//   channel  | direction | signals
//   ---------+-----------+----------------------------------------------
//   command  | in        | start, busy, background_pixel, foreground_pixel
//   result   | out       | done, blended_pixel
//
// One pixel pair is taken every clock; busy is always low.
// Two arithmetic stages (products, then weighted sum and alpha) are
// followed by four divider stages, two quotient bits each.
// The result is valid for the single cycle that done is high.
// Reset (rst_n low, asynchronous) clears the valid bits and drops any
// pixels in flight; the result side cannot stall.
// ----------------------------------------------------------------------------
`default_nettype none

module alpha_over_blend
    import aob_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [31:0] background_pixel,
    input  wire logic [31:0] foreground_pixel,
    output logic             done,
    output logic [31:0]      blended_pixel
);

    logic            accept;
    logic [CH_W-1:0] fa;
    logic [CH_W-1:0] ba;

    // Stage 1: products
    logic              v1_reg;
    logic [PROD_W-1:0] p_fc_reg [NUM_CH];
    logic [PROD_W-1:0] p_bc_reg [NUM_CH];
    logic [CH_W-1:0]   ia_reg;
    logic [PROD_W-1:0] n_reg;
    logic [PROD_W-1:0] n_next;

    // Stage 2: dividends, alpha
    logic              v2_reg;
    logic [NUM_W-1:0]  dvd_reg [NUM_CH];
    logic [NUM_W-1:0]  dvd_next [NUM_CH];
    logic [PROD_W-1:0] den_reg;
    logic [CH_W-1:0]   alpha2_reg;
    logic [CH_W-1:0]   alpha2_next;
    logic              zero2_reg;

    // Side band through the divider stages
    logic              v_pipe_reg     [DIV_STAGES];
    logic [CH_W-1:0]   alpha_pipe_reg [DIV_STAGES];
    logic              zero_pipe_reg  [DIV_STAGES];

    logic [CH_W-1:0]   quo [NUM_CH];

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign fa     = foreground_pixel[31:24];
    assign ba     = background_pixel[31:24];

    // Coverage term N = 65025 - (255 - fa)(255 - ba)
    assign n_next = COVER_MAX - (PROD_W'(ALPHA_MAX - fa) * PROD_W'(ALPHA_MAX - ba));

    // Stage 1 valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else
            v1_reg <= accept;
    end

    // Stage 1 payload: per-channel alpha weighted products
    always_ff @(posedge clk)
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            p_fc_reg[c] <= PROD_W'(foreground_pixel[c*CH_W +: CH_W]) * PROD_W'(fa);
            p_bc_reg[c] <= PROD_W'(background_pixel[c*CH_W +: CH_W]) * PROD_W'(ba);
        end
        ia_reg <= ALPHA_MAX - fa;
        n_reg  <= n_next;
    end

    // Stage 2 math: 255*fc*fa + bc*ba*(255-fa) + N - 1, and ceil(N / 255)
    always_comb
    begin
        logic [PROD_W:0] ax;
        logic [PROD_W:0] aq;
        for (int c = 0; c < NUM_CH; c++)
        begin
            dvd_next[c] = ({p_fc_reg[c], 8'b0} - NUM_W'(p_fc_reg[c]))
                        + (NUM_W'(p_bc_reg[c]) * NUM_W'(ia_reg))
                        + NUM_W'(n_reg) - NUM_W'(1);
        end
        ax          = {1'b0, n_reg} + CEIL_BIAS;
        aq          = ax + (ax >> 8) + (PROD_W+1)'(1);
        alpha2_next = aq[PROD_W-1:CH_W];
    end

    // Stage 2 valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else
            v2_reg <= v1_reg;
    end

    // Stage 2 payload
    always_ff @(posedge clk)
    begin
        for (int c = 0; c < NUM_CH; c++)
            dvd_reg[c] <= dvd_next[c];
        den_reg    <= n_reg;
        alpha2_reg <= alpha2_next;
        zero2_reg  <= (n_reg == '0);
    end

    // Colour dividers, one per channel
    genvar ch;
    generate
        for (ch = 0; ch < NUM_CH; ch++) begin : g_div
            aob_divider u_div (
                .clk      (clk),
                .dividend (dvd_reg[ch]),
                .divisor  (den_reg),
                .quotient (quo[ch])
            );
        end
    endgenerate

    // Valid bits alongside the divider
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < DIV_STAGES; s++)
                v_pipe_reg[s] <= 1'b0;
        end
        else
        begin
            v_pipe_reg[0] <= v2_reg;
            for (int s = 1; s < DIV_STAGES; s++)
                v_pipe_reg[s] <= v_pipe_reg[s-1];
        end
    end

    // Alpha and empty-pixel flag alongside the divider
    always_ff @(posedge clk)
    begin
        alpha_pipe_reg[0] <= alpha2_reg;
        zero_pipe_reg[0]  <= zero2_reg;
        for (int s = 1; s < DIV_STAGES; s++)
        begin
            alpha_pipe_reg[s] <= alpha_pipe_reg[s-1];
            zero_pipe_reg[s]  <= zero_pipe_reg[s-1];
        end
    end

    // Result: fully transparent pair gives an all-zero pixel
    assign done          = v_pipe_reg[DIV_STAGES-1];
    assign blended_pixel = zero_pipe_reg[DIV_STAGES-1] ? 32'h0 :
                           {alpha_pipe_reg[DIV_STAGES-1], quo[2], quo[1], quo[0]};

`ifndef SYNTHESIS
    // Every result traces back to an earlier command transfer
    a_done_has_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 6))
        else $error("result without a matching command transfer");

    // Opaque foreground always yields opaque result
    a_opaque_fg: assert property (@(posedge clk) disable iff (!rst_n)
        done && $past(foreground_pixel[31:24] == ALPHA_MAX, 6)
        |-> blended_pixel[31:24] == ALPHA_MAX)
        else $error("opaque foreground did not give opaque alpha");

    // Any coverage at all gives nonzero alpha
    a_alpha_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !zero_pipe_reg[DIV_STAGES-1] |-> blended_pixel[31:24] != '0)
        else $error("covered pixel came out with zero alpha");

    // Empty-pixel flag only for a fully transparent pair
    a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
        done && zero_pipe_reg[DIV_STAGES-1]
        |-> $past(foreground_pixel[31:24] == 8'h00, 6)
            && $past(background_pixel[31:24] == 8'h00, 6))
        else $error("empty-pixel flag set for a covered pair");
`endif

endmodule

`default_nettype wire
